/* hdl/ct11_pkg.sv */
// ---------------------------------------------------------------------------
// ct11_pkg - shared constants for the 11x11 census transform
// Window geometry, field widths, register indexes and reset values.
// ---------------------------------------------------------------------------
package ct11_pkg;

	// window geometry
	localparam int WIN   = 11;
	localparam int HALF  = 5;
	localparam int LINES = WIN - 1;

	// field widths
	localparam int PIX_W   = 8;
	localparam int CFG_W   = 12;
	localparam int CTR_W   = 11;
	localparam int DESC1_W = 64;
	localparam int DESC2_W = 56;
	localparam int DESC_W  = DESC1_W + DESC2_W;
	localparam int LINE_W  = LINES * PIX_W;

	// output stream word: center_row, center_col, desc_first, desc_second
	localparam int OUT_BITS = 2 * CTR_W + DESC_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// configuration registers
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
	localparam logic [CFG_W-1:0]     RST_WIDTH        = 12'd640;
	localparam logic [CFG_W-1:0]     RST_HEIGHT       = 12'd480;

	// default geometry limits
	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

endpackage

/* hdl/ct11_line_ram.sv */
// ---------------------------------------------------------------------------
// ct11_line_ram - line store memory
// One word per column holding the ten previous rows; one write and one
// registered read port.
// ---------------------------------------------------------------------------
module ct11_line_ram #(
	parameter int DEPTH  = ct11_pkg::DEF_MAX_WIDTH,
	parameter int DATA_W = ct11_pkg::LINE_W
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port, old data on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/ct11_window.sv */
// ---------------------------------------------------------------------------
// ct11_window - 11x11 window registers and census compare
// Shifts a new column in on the right and compares every neighbor of the
// shifted window against its center.
// ---------------------------------------------------------------------------
module ct11_window (
	input  logic                                            clk,
	input  logic                                            shift,
	input  logic [ct11_pkg::WIN-1:0][ct11_pkg::PIX_W-1:0]   column,
	output logic [ct11_pkg::DESC_W-1:0]                     desc
);

	localparam int CENTER_IDX = ct11_pkg::HALF * ct11_pkg::WIN + ct11_pkg::HALF;

	logic [ct11_pkg::PIX_W-1:0] win_q [ct11_pkg::WIN][ct11_pkg::WIN];
	logic [ct11_pkg::PIX_W-1:0] nxt   [ct11_pkg::WIN][ct11_pkg::WIN];

	// window after the shift: every row moves left, new column on the right
	always_comb begin
		for (int k = 0; k < ct11_pkg::WIN; k++) begin
			for (int l = 0; l < ct11_pkg::WIN - 1; l++) begin
				nxt[k][l] = win_q[k][l+1];
			end
			nxt[k][ct11_pkg::WIN-1] = column[k];
		end
	end

	// window registers, no reset
	always_ff @(posedge clk) begin
		if (shift) begin
			win_q <= nxt;
		end
	end

	// census bits: row by row, center skipped, first neighbor at the top bit
	always_comb begin
		int idx;
		int n;
		desc = '0;
		for (int k = 0; k < ct11_pkg::WIN; k++) begin
			for (int l = 0; l < ct11_pkg::WIN; l++) begin
				idx = k * ct11_pkg::WIN + l;
				n   = (idx > CENTER_IDX) ? idx - 1 : idx;
				if (idx != CENTER_IDX) begin
					desc[ct11_pkg::DESC_W-1-n] =
						(nxt[k][l] < nxt[ct11_pkg::HALF][ct11_pkg::HALF]);
				end
			end
		end
	end

endmodule

/* hdl/census_transform_11x11.sv */
// ---------------------------------------------------------------------------
// census_transform_11x11 - streaming 11x11 census transform
// Grey pixels in raster order in, one 120-bit descriptor per inner center out.
// ---------------------------------------------------------------------------
// Input stream: one 8-bit pixel per request, raster order, frame after frame.
// Output stream: one request per center at least five pixels from the top and
// left edges, sent when the pixel five rows below and five columns right of it
// arrives; border centers produce nothing.
// Throughput is one pixel per clock while the output is not stalled. The line
// store memory is read when a pixel is taken and written back when that pixel
// leaves the read stage; a forwarding register covers a read of the column
// that is being written in that same cycle. A descriptor passes the memory
// read stage, then the compare into the output register, before it shows on
// m_axis_tvalid. When m_axis_tready is low the output register holds its
// descriptor; the next pixel may still enter the read stage, and s_axis_tready
// drops only once both stages are full.
// Reset clears the position counters and the pipeline valid flags and sets
// image_width to 640 and image_height to 480. The line store and window
// contents are not cleared; no clearing pass is needed, as a descriptor only
// uses rows and columns written earlier in the frame.
// Write geometry through cfg_we/cfg_index/cfg_data while the stream is idle.
// ---------------------------------------------------------------------------
module census_transform_11x11 #(
	parameter int MAX_WIDTH  = ct11_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ct11_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// pixel input
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [ct11_pkg::PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel
	// descriptor output
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [10:0] center_row, [21:11] center_col, [85:22] desc_first,
	// [141:86] desc_second, [143:142] zero
	output logic [ct11_pkg::OUT_W-1:0]      m_axis_tdata,
	// configuration writes
	input  logic                            cfg_we,
	input  logic [ct11_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ct11_pkg::CFG_W-1:0]      cfg_data
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int GW  = ct11_pkg::CFG_W + 1;
	localparam int PW  = ct11_pkg::CTR_W + 1;
	localparam int PAD = ct11_pkg::OUT_W - ct11_pkg::OUT_BITS;

	logic [ct11_pkg::CFG_W-1:0] width_q, height_q;
	logic [CW-1:0]              col_q;
	logic [RW-1:0]              row_q;

	logic                       valid_s1;
	logic [ct11_pkg::PIX_W-1:0] pixel_s1;
	logic [CW-1:0]              col_s1;
	logic [RW-1:0]              row_s1;
	logic                       byp_s1;
	logic [ct11_pkg::LINE_W-1:0] byp_data_s1;

	logic                       out_valid_q;
	logic [ct11_pkg::CTR_W-1:0] center_row_q, center_col_q;
	logic [ct11_pkg::DESC_W-1:0] desc_q;

	logic                        acc_in, load_out, move_s1, hit_s1;
	logic                        col_wrap, row_wrap;
	logic [GW-1:0]               col_inc, row_inc;
	logic [ct11_pkg::LINE_W-1:0] rd_data, line_word, wr_data;
	logic [ct11_pkg::WIN-1:0][ct11_pkg::PIX_W-1:0] column;
	logic [ct11_pkg::DESC_W-1:0] desc;
	logic [PW-1:0]               ctr_row, ctr_col;

	// handshakes
	assign acc_in        = s_axis_tvalid && s_axis_tready;
	assign load_out      = !out_valid_q || m_axis_tready;
	assign move_s1       = valid_s1 && load_out;
	assign s_axis_tready = !valid_s1 || load_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ct11_pkg::RST_WIDTH;
			height_q <= ct11_pkg::RST_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_index)
				ct11_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				ct11_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// raster position; a bound above the maximum acts as the maximum
	assign col_inc  = GW'(col_q) + GW'(1);
	assign row_inc  = GW'(row_q) + GW'(1);
	assign col_wrap = (col_inc >= GW'(width_q)) || (col_inc == GW'(MAX_WIDTH));
	assign row_wrap = (row_inc >= GW'(height_q)) || (row_inc == GW'(MAX_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc_in) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_inc[RW-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// line store: read on accept, write back the shifted column one stage on
	ct11_line_ram #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (ct11_pkg::LINE_W)
	) u_line_ram (
		.clk     (clk),
		.rd_en   (acc_in),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (move_s1),
		.wr_addr (col_s1),
		.wr_data (wr_data)
	);

	// forwarded word wins when the read hit the column written that cycle
	assign line_word = byp_s1 ? byp_data_s1 : rd_data;
	assign wr_data   = {pixel_s1, line_word[ct11_pkg::LINE_W-1:ct11_pkg::PIX_W]};
	assign column    = {pixel_s1, line_word};

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc_in) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (acc_in) begin
			pixel_s1    <= s_axis_tdata;
			col_s1      <= col_q;
			row_s1      <= row_q;
			byp_s1      <= move_s1 && (col_q == col_s1);
			byp_data_s1 <= wr_data;
		end
	end

	// window and compare
	ct11_window u_window (
		.clk    (clk),
		.shift  (move_s1),
		.column (column),
		.desc   (desc)
	);

	// emit only once the full window lies inside the frame
	assign hit_s1  = (row_s1 >= RW'(ct11_pkg::LINES)) && (col_s1 >= CW'(ct11_pkg::LINES));
	assign ctr_row = PW'(row_s1) - PW'(ct11_pkg::HALF);
	assign ctr_col = PW'(col_s1) - PW'(ct11_pkg::HALF);

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= move_s1 && hit_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out && move_s1 && hit_s1) begin
			center_row_q <= ctr_row[ct11_pkg::CTR_W-1:0];
			center_col_q <= ctr_col[ct11_pkg::CTR_W-1:0];
			desc_q       <= desc;
		end
	end

	// desc_q holds the first 64 bits on top; desc_first goes below desc_second
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PAD{1'b0}},
		desc_q[ct11_pkg::DESC2_W-1:0],
		desc_q[ct11_pkg::DESC_W-1:ct11_pkg::DESC2_W],
		center_col_q, center_row_q};

endmodule
